### src/lioff_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lioff_pkg: shared types and constants of the line index block
// Field widths, item kinds, character codes and the control/status bundles
// between the controller and the datapath.
// ---------------------------------------------------------------------------
package lioff_pkg;

    localparam int KIND_W      = 2;
    localparam int BYTE_W      = 8;
    localparam int OFF_W       = 21;
    localparam int QLINE_W     = 16;
    localparam int LNUM_W      = 13;
    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 64;

    localparam int unsigned MAX_TEXT_BYTES_DEF   = 1048576;
    localparam int unsigned LINE_TABLE_DEPTH_DEF = 4096;
    // the byte counter never counts past this, whatever the text limit
    localparam int unsigned COUNT_LIMIT          = 2097151;

    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_LOAD   = 2'd1,
        KIND_OFFSET = 2'd2,
        KIND_LINE   = 2'd3
    } t_kind;

    typedef struct packed {
        logic accept;       // input item taken this cycle
        logic rd_issue;     // read the table at the search address
        logic search_step;  // narrow the search window
        logic res_load;     // write the query result to the output register
    } t_cmd;

    typedef struct packed {
        logic search_done;  // window has closed on one entry
    } t_stat;

endpackage

### src/lioff_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lioff_ctrl: sequencer of the line index block
// Runs the handshakes, the output valid flag and the read/compare loop of
// the table search.
// ---------------------------------------------------------------------------
module lioff_ctrl
    import lioff_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_s_valid,
    input  t_kind  i_kind,
    output logic   o_s_ready,
    output logic   o_m_valid,
    input  logic   i_m_ready,
    input  t_stat  i_stat,
    output t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CMP  = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   is_query;

    assign out_free  = !r_out_valid || i_m_ready;
    assign is_query  = (i_kind == KIND_OFFSET) || (i_kind == KIND_LINE);
    assign o_s_ready = (r_state == S_IDLE) && out_free;
    assign o_m_valid = r_out_valid;

    always_comb begin
        n_state            = r_state;
        o_cmd              = '0;
        o_cmd.accept       = i_s_valid && o_s_ready;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept && is_query) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_CMP;
            end
            S_CMP: begin
                if (!i_stat.search_done) begin
                    o_cmd.search_step = 1'b1;
                    n_state           = S_READ;
                end else if (out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if ((o_cmd.accept && !is_query) || o_cmd.res_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### src/lioff_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lioff_dp: datapath of the line index block
// Holds the counters, the line start memory, the search window and the
// output payload register.
// ---------------------------------------------------------------------------
module lioff_dp
    import lioff_pkg::*;
#(
    parameter int unsigned MAX_TEXT_BYTES   = MAX_TEXT_BYTES_DEF,
    parameter int unsigned LINE_TABLE_DEPTH = LINE_TABLE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  t_kind               i_kind,
    input  logic [BYTE_W-1:0]   i_data_byte,
    input  logic [OFF_W-1:0]    i_query_offset,
    input  logic [QLINE_W-1:0]  i_query_line,
    output logic                o_found,
    output logic [LNUM_W-1:0]   o_line_number,
    output logic [OFF_W-1:0]    o_column,
    output logic [OFF_W-1:0]    o_line_offset,
    output logic                o_table_full
);

    localparam int IDX_W = $clog2(LINE_TABLE_DEPTH);
    localparam int CNT_W = $clog2(LINE_TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LINE_TABLE_DEPTH);
    localparam logic [31:0] LOAD_LIMIT =
        (MAX_TEXT_BYTES < COUNT_LIMIT) ? MAX_TEXT_BYTES : COUNT_LIMIT;

    logic [OFF_W-1:0] r_mem [LINE_TABLE_DEPTH];

    logic [CNT_W-1:0]   r_line_count, n_line_count;
    logic [OFF_W-1:0]   r_byte_count, n_byte_count;
    logic               r_cr_pend, n_cr_pend;
    logic               r_overflow, n_overflow;

    logic               r_q_line_kind;
    logic [OFF_W-1:0]   r_qoff;
    logic [QLINE_W-1:0] r_qline;
    logic [IDX_W-1:0]   r_lo, r_hi;
    logic [OFF_W-1:0]   r_rd_data;

    logic               r_found;
    logic [LNUM_W-1:0]  r_lnum;
    logic [OFF_W-1:0]   r_col, r_loff;
    logic               r_full;

    logic [CNT_W-1:0]   entries;
    logic               room, load_ok, add_start, wr_en;
    logic [OFF_W-1:0]   add_pos;
    logic               cur_full, next_full;
    logic [CNT_W-1:0]   span;
    logic [IDX_W-1:0]   mid, rd_addr;
    logic [OFF_W-1:0]   mid_val, lo_val;
    logic [31:0]        acc_q32, res_q32, n32, lnum32;
    logic               acc_in_range;
    logic               res_found;
    logic [OFF_W-1:0]   res_col, res_loff;

    // a CR as last byte counts as a break at the data length
    assign entries  = (r_cr_pend && (r_line_count < DEPTH_C)) ?
                      r_line_count + 1'b1 : r_line_count;
    assign room     = r_line_count < DEPTH_C;
    assign cur_full = r_overflow || (r_cr_pend && !room);
    assign n32      = 32'(entries);

    // byte load
    always_comb begin
        load_ok      = 32'(r_byte_count) < LOAD_LIMIT;
        add_start    = r_cr_pend || (i_data_byte == CH_LF);
        add_pos      = (i_data_byte == CH_LF) ? r_byte_count + 1'b1 : r_byte_count;
        n_line_count = r_line_count;
        n_byte_count = r_byte_count;
        n_cr_pend    = r_cr_pend;
        n_overflow   = r_overflow;
        wr_en        = 1'b0;
        if (load_ok) begin
            n_byte_count = r_byte_count + 1'b1;
            n_cr_pend    = (i_data_byte == CH_CR);
            if (add_start) begin
                if (room) begin
                    wr_en        = 1'b1;
                    n_line_count = r_line_count + 1'b1;
                end else begin
                    n_overflow = 1'b1;
                end
            end
        end
        next_full = n_overflow || (n_cr_pend && !(n_line_count < DEPTH_C));
    end

    // search window: find the last entry not above the offset
    always_comb begin
        span    = CNT_W'(r_hi) - CNT_W'(r_lo) + 1'b1;
        mid     = r_lo + IDX_W'(span >> 1);
        rd_addr = (r_lo == r_hi) ? r_lo : mid;
        mid_val = (CNT_W'(mid) < r_line_count) ? r_rd_data : r_byte_count;
        if (r_lo == '0) begin
            lo_val = '0;
        end else if (CNT_W'(r_lo) < r_line_count) begin
            lo_val = r_rd_data;
        end else begin
            lo_val = r_byte_count;
        end
    end

    assign o_stat.search_done = (r_lo == r_hi);

    assign acc_q32      = 32'(i_query_line);
    assign acc_in_range = (acc_q32 != '0) && ((acc_q32 - 1) < n32);
    assign res_q32      = 32'(r_qline);

    // query result from the closed window
    always_comb begin
        res_found = 1'b0;
        lnum32    = '0;
        res_col   = '0;
        res_loff  = '0;
        if (r_q_line_kind) begin
            if (res_q32 != '0) begin
                if ((res_q32 - 1) == n32) begin
                    res_found = 1'b1;
                    res_loff  = r_byte_count;
                end else if ((res_q32 - 1) < n32) begin
                    res_found = 1'b1;
                    res_loff  = lo_val;
                end
            end
        end else begin
            if (r_qoff == r_byte_count) begin
                res_found = 1'b1;
                lnum32    = n32;
            end else if (r_qoff < r_byte_count) begin
                res_found = 1'b1;
                lnum32    = 32'(r_lo) + 1;
                res_col   = r_qoff - lo_val + 1'b1;
            end
        end
    end

    // table memory: entry zero is never written and reads as zero above
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_kind == KIND_LOAD) && wr_en) begin
            r_mem[r_line_count[IDX_W-1:0]] <= add_pos;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count <= CNT_W'(1);
            r_byte_count <= '0;
            r_cr_pend    <= 1'b0;
            r_overflow   <= 1'b0;
        end else if (i_cmd.accept) begin
            case (i_kind)
                KIND_CLEAR: begin
                    r_line_count <= CNT_W'(1);
                    r_byte_count <= '0;
                    r_cr_pend    <= 1'b0;
                    r_overflow   <= 1'b0;
                end
                KIND_LOAD: begin
                    r_line_count <= n_line_count;
                    r_byte_count <= n_byte_count;
                    r_cr_pend    <= n_cr_pend;
                    r_overflow   <= n_overflow;
                end
                default: begin
                end
            endcase
        end
    end

    // query registers and search window
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_q_line_kind <= (i_kind == KIND_LINE);
            r_qoff        <= i_query_offset;
            r_qline       <= i_query_line;
            if (i_kind == KIND_LINE) begin
                r_lo <= acc_in_range ? IDX_W'(acc_q32 - 1) : '0;
                r_hi <= acc_in_range ? IDX_W'(acc_q32 - 1) : '0;
            end else begin
                r_lo <= '0;
                r_hi <= IDX_W'(entries - 1'b1);
            end
        end else if (i_cmd.search_step) begin
            if (mid_val <= r_qoff) begin
                r_lo <= mid;
            end else begin
                r_hi <= mid - 1'b1;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_kind == KIND_CLEAR)) begin
            r_found <= 1'b1;
            r_lnum  <= '0;
            r_col   <= '0;
            r_loff  <= '0;
            r_full  <= 1'b0;
        end else if (i_cmd.accept && (i_kind == KIND_LOAD)) begin
            r_found <= load_ok;
            r_lnum  <= '0;
            r_col   <= '0;
            r_loff  <= '0;
            r_full  <= next_full;
        end else if (i_cmd.res_load) begin
            r_found <= res_found;
            r_lnum  <= lnum32[LNUM_W-1:0];
            r_col   <= res_col;
            r_loff  <= res_loff;
            r_full  <= cur_full;
        end
    end

    assign o_found       = r_found;
    assign o_line_number = r_lnum;
    assign o_column      = r_col;
    assign o_line_offset = r_loff;
    assign o_table_full  = r_full;

endmodule

### src/line_index_offset_lookup.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_index_offset_lookup: line start table with offset and line lookup
// Loads text bytes, records where each line starts and answers offset to
// line/column and line to offset queries by binary search.
// ---------------------------------------------------------------------------
// Clear and byte load items complete in the cycle they are taken, so loads
// stream at one item per cycle while the result side keeps up. An offset
// query runs a binary search over the line start memory, which has a single
// registered read port: each halving step takes a read state and a compare
// state, and a line query passes through each of them once. No input is taken
// while a query runs. The memory needs no clearing pass after reset: only
// entries below the line count are ever used, and entry zero reads as zero.
module line_index_offset_lookup
    import lioff_pkg::*;
#(
    parameter int unsigned MAX_TEXT_BYTES   = MAX_TEXT_BYTES_DEF,
    parameter int unsigned LINE_TABLE_DEPTH = LINE_TABLE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // data_byte[7:0], query_offset[28:8], query_line[44:29], zero[47:45]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // kind[1:0]
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // found[0], line_number[13:1], column[34:14], line_offset[55:35],
    // table_full[56], zero[63:57]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    t_cmd               cmd;
    t_stat              stat;
    t_kind              kind;
    logic               found, table_full;
    logic [LNUM_W-1:0]  line_number;
    logic [OFF_W-1:0]   column, line_offset;

    assign kind = t_kind'(i_s_axis_tuser[KIND_W-1:0]);

    lioff_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_kind    (kind),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    lioff_dp #(
        .MAX_TEXT_BYTES   (MAX_TEXT_BYTES),
        .LINE_TABLE_DEPTH (LINE_TABLE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_kind         (kind),
        .i_data_byte    (i_s_axis_tdata[7:0]),
        .i_query_offset (i_s_axis_tdata[28:8]),
        .i_query_line   (i_s_axis_tdata[44:29]),
        .o_found        (found),
        .o_line_number  (line_number),
        .o_column       (column),
        .o_line_offset  (line_offset),
        .o_table_full   (table_full)
    );

    assign o_m_axis_tdata = {7'd0, table_full, line_offset, column, line_number, found};

endmodule
